// ===== rtl/fdr_pkg.sv =====
// Package: shared types and constants for the FDR step-up rejection block.
`timescale 1ns / 1ps
package fdr_pkg;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int PVALUE_BITS_DEF = 16;
	localparam int HARM_FRAC = 24;
	localparam int LEVEL_BITS = 16;
	localparam int INDEX_BITS = 6;
	localparam logic [15:0] LEVEL_RESET = 16'd3277;
	localparam logic [0:0] CONS_RESET = 1'b1;
	localparam logic [0:0] REG_LEVEL = 1'b0;
	localparam logic [0:0] REG_CONS = 1'b1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_HARM,
		ST_DIV,
		ST_RANK_RD,
		ST_RANK_CMP,
		ST_RANK_NEXT,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ===== rtl/fdr_div.sv =====
// Restoring divider: 2^HF/j and level*2^HF/harmonic sum, one quotient bit per cycle.
`timescale 1ns / 1ps
module fdr_div #(
	parameter int NUM_BITS = 40,
	parameter int DEN_BITS = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output fdr_pkg::div_ctl_t   ctl,
	output logic [NUM_BITS-1:0] quo
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);
	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DEN_BITS:0] trial;

	assign trial = {rem_q[DEN_BITS-1:0], num_q[NUM_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !busy_q) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_BITS-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo <= {quo[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo <= {quo[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = go && !busy_q;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
endmodule

// ===== rtl/fdr_step_up_rejection_top.sv =====
// Top level: step-up FDR rejection (BH, or BY in conservative mode) over stored p-values.
`timescale 1ns / 1ps
// channel | signals                                  | direction
// input   | start, busy, pvalue, final_item          | in (busy out)
// result  | out_valid, item_index, rejected,         | out, one-cycle strobe
//         | last_result, overflowed                  |
// config  | psel, penable, pwrite, paddr, pwdata,    | APB, pready tied high
//         | prdata, pready                           |
// Loading accepts one p-value per cycle until the final item. After it, in
// conservative mode only: m reciprocal divides (one per term) summed into the
// harmonic sum, then one level divide; then for each candidate rank, from m
// downward, a sweep of the store, then one result per item is emitted. No new
// set is taken until the last result; sweeps share the single store read port.
// Reset clears counters and state; store contents are undefined until loaded.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fdr_step_up_rejection_top #(
	parameter int MAX_ITEMS = fdr_pkg::MAX_ITEMS_DEF,
	parameter int PVALUE_BITS = fdr_pkg::PVALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [PVALUE_BITS-1:0] pvalue,
	input  logic                   final_item,
	output logic                   out_valid,
	output logic [5:0]             item_index,
	output logic                   rejected,
	output logic                   last_result,
	output logic                   overflowed,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int HF = fdr_pkg::HARM_FRAC;
	localparam int HW = HF + CW + 1;        // harmonic sum width
	localparam int NW = fdr_pkg::LEVEL_BITS + HF; // divide numerator width
	localparam int DW = (HW > NW) ? HW : NW;
	localparam int PW = PVALUE_BITS + CW;    // product width

	fdr_pkg::state_t state_q, state_d;

	logic [15:0] level_q;
	logic cons_q;
	logic [CW-1:0] count_q;
	logic ovf_q;
	logic [PVALUE_BITS-1:0] store [MAX_ITEMS];
	logic [PVALUE_BITS-1:0] rd_s1;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] j_q;      // harmonic term / rank index
	logic [CW-1:0] i_q;      // sweep index
	logic [CW-1:0] hits_q;
	logic [HW-1:0] harm_q;
	logic [DW-1:0] eff_q;    // effective level
	logic [CW-1:0] best_q;
	logic accept, wr_en;

	logic div_go;
	logic [DW-1:0] div_num, div_den, div_quo;
	fdr_pkg::div_ctl_t div_ctl;

	fdr_div #(.NUM_BITS(DW), .DEN_BITS(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(div_den),
		.ctl(div_ctl), .quo(div_quo)
	);

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign accept = start && !busy;
	assign busy = (state_q != fdr_pkg::ST_LOAD);

	always_comb begin
		prdata = '0;
		case (paddr[2])
			fdr_pkg::REG_LEVEL: prdata = {16'd0, level_q};
			fdr_pkg::REG_CONS:  prdata = {31'd0, cons_q};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= fdr_pkg::LEVEL_RESET;
			cons_q <= fdr_pkg::CONS_RESET;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			case (paddr[2])
				fdr_pkg::REG_LEVEL: level_q <= pwdata[15:0];
				fdr_pkg::REG_CONS:  cons_q <= pwdata[0];
				default:            level_q <= level_q;
			endcase
		end
	end

	// Store: one write port for loading, one registered read port for sweeps and emission.
	always_comb begin
		rd_addr = i_q[AW-1:0];
	end
	always_ff @(posedge clk) begin
		if (accept && count_q != CW'(MAX_ITEMS))
			store[count_q[AW-1:0]] <= pvalue;
		rd_s1 <= store[rd_addr];
	end

	// Divider operands: reciprocal terms, then the conservative level.
	always_comb begin
		div_go = 1'b0;
		div_num = '0;
		div_den = DW'(1);
		case (state_q)
			fdr_pkg::ST_HARM: begin
				div_go = !div_ctl.busy && !div_ctl.done;
				div_num = DW'(1) << HF;
				div_den = DW'(j_q);
			end
			fdr_pkg::ST_DIV: begin
				div_go = !div_ctl.busy && !div_ctl.done;
				div_num = DW'({level_q, {HF{1'b0}}});
				div_den = DW'(harm_q);
			end
			default: div_go = 1'b0;
		endcase
	end

	logic [PW-1:0] lhs;
	logic [DW+CW-1:0] bound;
	logic hit;
	assign lhs = PW'(rd_s1) * PW'(count_q);
	assign bound = (DW+CW)'(eff_q) * (DW+CW)'(j_q);
	assign hit = (DW+CW)'(lhs) <= bound;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdr_pkg::ST_LOAD:
				if (accept && final_item)
					state_d = cons_q ? fdr_pkg::ST_HARM : fdr_pkg::ST_RANK_RD;
			fdr_pkg::ST_HARM:
				if (div_ctl.done && j_q == count_q) state_d = fdr_pkg::ST_DIV;
			fdr_pkg::ST_DIV:
				if (div_ctl.done) state_d = fdr_pkg::ST_RANK_RD;
			fdr_pkg::ST_RANK_RD: state_d = fdr_pkg::ST_RANK_CMP;
			fdr_pkg::ST_RANK_CMP:
				if (i_q == count_q) state_d = fdr_pkg::ST_RANK_NEXT;
			fdr_pkg::ST_RANK_NEXT:
				if (hits_q >= j_q || j_q == CW'(1)) state_d = fdr_pkg::ST_EMIT_RD;
				else state_d = fdr_pkg::ST_RANK_RD;
			fdr_pkg::ST_EMIT_RD: state_d = fdr_pkg::ST_EMIT;
			fdr_pkg::ST_EMIT:
				state_d = (i_q + 1'b1 == count_q) ? fdr_pkg::ST_LOAD : fdr_pkg::ST_EMIT_RD;
			default: state_d = fdr_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdr_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			j_q <= '0;
			i_q <= '0;
			hits_q <= '0;
			harm_q <= '0;
			eff_q <= '0;
			best_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				fdr_pkg::ST_LOAD: if (accept) begin
					if (count_q != CW'(MAX_ITEMS)) count_q <= count_q + 1'b1;
					else ovf_q <= 1'b1;
					j_q <= CW'(1);
					harm_q <= '0;
					i_q <= '0;
					hits_q <= '0;
					eff_q <= DW'(level_q);
					if (final_item && !cons_q)
						j_q <= (count_q != CW'(MAX_ITEMS)) ? count_q + 1'b1 : count_q;
				end
				fdr_pkg::ST_HARM: if (div_ctl.done) begin
					harm_q <= harm_q + HW'(div_quo);
					j_q <= j_q + 1'b1;
				end
				fdr_pkg::ST_DIV: if (div_ctl.done) begin
					eff_q <= div_quo;
					j_q <= count_q;
				end
				fdr_pkg::ST_RANK_RD: begin
					i_q <= CW'(1);
					hits_q <= '0;
				end
				fdr_pkg::ST_RANK_CMP: begin
					if (hit) hits_q <= hits_q + 1'b1;
					if (i_q != count_q) i_q <= i_q + 1'b1;
				end
				fdr_pkg::ST_RANK_NEXT: begin
					i_q <= '0;
					if (hits_q >= j_q) best_q <= j_q;
					else if (j_q == CW'(1)) best_q <= '0;
					else j_q <= j_q - 1'b1;
				end
				fdr_pkg::ST_EMIT: begin
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == count_q) begin
						count_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// RANK_RD reads entry 0; each CMP cycle compares the entry held in the read
	// register from the previous address and issues the next one, so the read runs one ahead.
	// In EMIT the rejection test uses best_q directly (set when the rank search exits).
	logic [DW+CW-1:0] rej_bound;
	assign rej_bound = (DW+CW)'(eff_q) * (DW+CW)'(best_q);
	always_comb begin
		out_valid = (state_q == fdr_pkg::ST_EMIT);
		item_index = 6'(i_q);
		rejected = (best_q != '0) && ((DW+CW)'(lhs) <= rej_bound);
		last_result = (i_q + 1'b1 == count_q);
		overflowed = ovf_q;
	end

	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy) else $error("result while idle");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdr_pkg::ST_EMIT && last_result) |=> !busy)
		else $error("not idle after last result");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS)) else $error("count beyond capacity");
endmodule
